// ===== hdl/ctb_pkg.sv =====
// Shared types, widths and codes for the cycle-counter timebase calibrator.
`default_nettype none

package ctb_pkg;

    // Field and register widths
    localparam int WORD_W    = 64;
    localparam int OP_W      = 2;
    localparam int DLY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int MS_W      = 10;
    localparam int CALT_W    = 8;
    localparam int US_W      = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 10;

    // Reset values and fixed scale
    localparam int US_PER_MS  = 1000;
    localparam int MS_RESET   = 10;
    localparam int CALT_RESET = 50;
    localparam int US_RESET   = MS_RESET * US_PER_MS;

    // Serial unit sizing
    localparam int MUL_B_W   = DLY_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam int DIV_CNT_W = $clog2(WORD_W);

    // Operation codes
    localparam logic [OP_W-1:0] OP_CAL  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_ARM  = 2'd2;
    localparam logic [OP_W-1:0] OP_POLL = 2'd3;

    // Calibration phases
    localparam logic [STAT_W-1:0] PH_WAIT = 2'd0;
    localparam logic [STAT_W-1:0] PH_MEAS = 2'd1;
    localparam logic [STAT_W-1:0] PH_CAL  = 2'd2;
    localparam logic [STAT_W-1:0] PH_FAIL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TICKS   = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] cycle_count;
        logic [WORD_W-1:0] ref_ticks;
        logic [DLY_W-1:0]  delay_us;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] time_us;
        logic [STAT_W-1:0] cal_status;
        logic              delay_done;
    } out_t;

endpackage

`default_nettype wire

// ===== hdl/ctb_mul.sv =====
// Serial shift-and-add multiplier: one multiplier bit per cycle, product modulo 2^64.
`default_nettype none

module ctb_mul
    import ctb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_W-1:0]    mcand,
    input  wire logic [MUL_B_W-1:0]   mplier,
    input  wire logic [MUL_CNT_W-1:0] nbits,
    output logic                      done,
    output logic [WORD_W-1:0]         product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]    a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;

    // Load on start, then consume one multiplier bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            acc_next  = '0;
            a_next    = mcand;
            b_next    = mplier;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[WORD_W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/ctb_div.sv =====
// Serial restoring divider: one quotient bit per cycle, 64-bit dividend and divisor.
`default_nettype none

module ctb_div
    import ctb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [WORD_W-1:0] divisor,
    output logic                   done,
    output logic [WORD_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;

    // Shift the next dividend bit into the remainder and try the subtract
    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(WORD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/cycle_counter_timebase_calibrator_unit.sv =====
// Top level of the cycle-counter timebase calibrator: sequencer, state and output register.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------------------------------
//  in      | in        | in_valid / in_stall  | in_t: op, cycle_count, ref_ticks, delay_us
//  out     | out       | out_valid / out_stall| out_t: time_us, cal_status, delay_done
//  cfg     | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// One item at a time. Polls, plain samples, failed-range reads and zero-tick arms go
// from decode to the result register; a tick-time read uses the serial multiplier, a
// delay arm the multiplier (one bit of the 32-bit delay a cycle) or the serial divider
// (one quotient bit a cycle); a calibrated read uses the divider, the end sample both.
// The next beat is taken once the result has been moved into the output register, which
// then holds it through out_stall. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module cycle_counter_timebase_calibrator_unit
    import ctb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_t                      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    in_t                 item_reg;
    logic [US_W-1:0]     us_per_tick_reg;
    logic [CALT_W-1:0]   cal_ticks_reg;
    logic [STAT_W-1:0]   phase_reg, phase_next;
    logic                have_first_reg, have_first_next;
    logic [WORD_W-1:0]   first_tick_reg, first_tick_next;
    logic [WORD_W-1:0]   start_cycles_reg, start_cycles_next;
    logic [WORD_W-1:0]   start_tick_reg, start_tick_next;
    logic [WORD_W-1:0]   rate_reg, rate_next;
    logic [WORD_W-1:0]   origin_reg, origin_next;
    logic [WORD_W-1:0]   deadline_reg, deadline_next;
    logic                in_ticks_reg, in_ticks_next;
    logic [WORD_W-1:0]   t_reg, t_next;
    logic                res_done_reg, res_done_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg, out_next;

    logic                in_take;
    logic                out_free;
    logic [WORD_W-1:0]   waited;
    logic [WORD_W-1:0]   cal_cycles;
    logic [WORD_W-1:0]   since_origin;
    logic                per_zero;

    logic                mul_start;
    logic [WORD_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_CNT_W-1:0] mul_nbits;
    logic                mul_done;
    logic [WORD_W-1:0]   mul_product;

    logic                div_start;
    logic [WORD_W-1:0]   div_dividend;
    logic [WORD_W-1:0]   div_divisor;
    logic                div_done;
    logic [WORD_W-1:0]   div_quotient;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Differences against the stored marks
    assign waited       = item_reg.ref_ticks - start_tick_reg;
    assign cal_cycles   = item_reg.cycle_count - start_cycles_reg;
    assign since_origin = item_reg.cycle_count - origin_reg;
    assign per_zero     = (us_per_tick_reg == '0);

    // Steer operands to the multiplier
    always_comb
    begin
        mul_a     = item_reg.ref_ticks;
        mul_b     = MUL_B_W'(us_per_tick_reg);
        mul_nbits = MUL_CNT_W'(US_W);
        case (item_reg.op)
            OP_CAL:
            begin
                mul_a = waited;
            end
            OP_ARM:
            begin
                mul_a     = rate_reg;
                mul_b     = item_reg.delay_us;
                mul_nbits = MUL_CNT_W'(MUL_B_W);
            end
            default:
            begin
                mul_a = item_reg.ref_ticks;
            end
        endcase
    end

    // Steer operands to the divider
    always_comb
    begin
        div_dividend = WORD_W'(item_reg.delay_us) + WORD_W'(us_per_tick_reg) - WORD_W'(1);
        div_divisor  = WORD_W'(us_per_tick_reg);
        case (item_reg.op)
            OP_CAL:
            begin
                div_dividend = cal_cycles;
                div_divisor  = mul_product;
            end
            OP_READ:
            begin
                div_dividend = since_origin;
                div_divisor  = rate_reg;
            end
            default:
            begin
                div_divisor = WORD_W'(us_per_tick_reg);
            end
        endcase
    end

    // Sequence one item through decode, the serial units and the result register
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        have_first_next   = have_first_reg;
        first_tick_next   = first_tick_reg;
        start_cycles_next = start_cycles_reg;
        start_tick_next   = start_tick_reg;
        rate_next         = rate_reg;
        origin_next       = origin_reg;
        deadline_next     = deadline_reg;
        in_ticks_next     = in_ticks_reg;
        t_next            = t_reg;
        res_done_next     = res_done_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        mul_start         = 1'b0;
        div_start         = 1'b0;

        // Drop the delivered beat
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                t_next        = '0;
                res_done_next = 1'b0;
                state_next    = ST_OUT;
                case (item_reg.op)
                    OP_CAL:
                    begin
                        if (phase_reg == PH_WAIT)
                        begin
                            if (!have_first_reg)
                            begin
                                have_first_next = 1'b1;
                                first_tick_next = item_reg.ref_ticks;
                            end
                            else if (item_reg.ref_ticks != first_tick_reg)
                            begin
                                have_first_next   = 1'b0;
                                start_cycles_next = item_reg.cycle_count;
                                start_tick_next   = item_reg.ref_ticks;
                                phase_next        = PH_MEAS;
                            end
                        end
                        else if (phase_reg == PH_MEAS)
                        begin
                            if (waited >= WORD_W'(cal_ticks_reg))
                            begin
                                mul_start  = 1'b1;
                                state_next = ST_MUL;
                            end
                        end
                    end
                    OP_READ:
                    begin
                        if (phase_reg != PH_CAL || rate_reg == '0)
                        begin
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                        else if (item_reg.cycle_count >= origin_reg)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    OP_ARM:
                    begin
                        if (phase_reg == PH_CAL)
                        begin
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                        else if (per_zero)
                        begin
                            deadline_next = item_reg.ref_ticks;
                            in_ticks_next = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        if (in_ticks_reg)
                        begin
                            res_done_next = (item_reg.ref_ticks >= deadline_reg);
                        end
                        else
                        begin
                            res_done_next = (item_reg.cycle_count >= deadline_reg);
                        end
                    end
                endcase
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_OUT;
                    case (item_reg.op)
                        OP_CAL:
                        begin
                            if (mul_product == '0 || cal_cycles == '0)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        OP_READ:
                        begin
                            t_next = mul_product;
                        end
                        default:
                        begin
                            deadline_next = item_reg.cycle_count + mul_product;
                            in_ticks_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                    case (item_reg.op)
                        OP_CAL:
                        begin
                            if (div_quotient == '0)
                            begin
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                rate_next   = div_quotient;
                                origin_next = item_reg.cycle_count;
                                phase_next  = PH_CAL;
                            end
                        end
                        OP_READ:
                        begin
                            t_next = div_quotient;
                        end
                        default:
                        begin
                            deadline_next = item_reg.ref_ticks + div_quotient;
                            in_ticks_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_OUT:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.time_us    = (item_reg.op == OP_READ) ? t_reg : rate_reg;
                    out_next.cal_status = phase_reg;
                    out_next.delay_done = res_done_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ctb_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .nbits   (mul_nbits),
        .done    (mul_done),
        .product (mul_product)
    );

    ctb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Configuration registers; keep the tick length in microseconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_per_tick_reg <= US_W'(US_RESET);
            cal_ticks_reg   <= CALT_W'(CALT_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MS_PER_TICK:
                begin
                    us_per_tick_reg <= US_W'(cfg_data[MS_W-1:0]) * US_W'(US_PER_MS);
                end
                CFG_CAL_TICKS:
                begin
                    cal_ticks_reg <= cfg_data[CALT_W-1:0];
                end
                default:
                begin
                    cal_ticks_reg <= cal_ticks_reg;
                end
            endcase
        end
    end

    // Control and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_WAIT;
            have_first_reg   <= 1'b0;
            first_tick_reg   <= '0;
            start_cycles_reg <= '0;
            start_tick_reg   <= '0;
            rate_reg         <= '0;
            origin_reg       <= '0;
            deadline_reg     <= '0;
            in_ticks_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            have_first_reg   <= have_first_next;
            first_tick_reg   <= first_tick_next;
            start_cycles_reg <= start_cycles_next;
            start_tick_reg   <= start_tick_next;
            rate_reg         <= rate_next;
            origin_reg       <= origin_next;
            deadline_reg     <= deadline_next;
            in_ticks_reg     <= in_ticks_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        t_reg        <= t_next;
        res_done_reg <= res_done_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ctb_checker.sv =====
// Port-level checker for the calibrator top level, with its bind.
`default_nettype none

module ctb_checker
    import ctb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    logic              in_beat;
    logic              out_beat;
    logic [1:0]        pending_reg, pending_next;
    logic              seen_reg, seen_next;
    logic [STAT_W-1:0] last_stat_reg, last_stat_next;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // Track beats in flight and the last delivered status
    always_comb
    begin
        pending_next   = pending_reg + {1'b0, in_beat} - {1'b0, out_beat};
        seen_next      = seen_reg || out_beat;
        last_stat_next = out_beat ? out_data.cal_status : last_stat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seen_reg      <= 1'b0;
            last_stat_reg <= PH_WAIT;
        end
        else
        begin
            pending_reg   <= pending_next;
            seen_reg      <= seen_next;
            last_stat_reg <= last_stat_next;
        end
    end

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // Go busy after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("input taken while previous item still in work");

    // At most one item in work and one result waiting
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2 && !(pending_reg == 2'd0 && out_valid))
        else $error("result count does not match accepted items");

    // Calibrated or failed status never reverts
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg && (last_stat_reg == PH_CAL || last_stat_reg == PH_FAIL)
        |-> out_data.cal_status == last_stat_reg)
        else $error("calibration status left a final phase");

endmodule

bind cycle_counter_timebase_calibrator_unit ctb_checker u_ctb_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the cycle-counter timebase calibrator: random traffic and scoreboard.
module tb;
    import ctb_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 600;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // Ways of ending the one calibration run
    localparam int CAL_GOOD      = 0;
    localparam int CAL_NO_CYCLES = 1;
    localparam int CAL_SLOW      = 2;
    localparam int CAL_NO_TIME   = 3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MS_PER_TICK;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Mirror of the block's registers and calibration state
    logic [MS_W-1:0]   ms_tick       = MS_W'(MS_RESET);
    logic [CALT_W-1:0] cal_span      = CALT_W'(CALT_RESET);
    logic [STAT_W-1:0] cal_phase     = PH_WAIT;
    logic              tick_seen     = 1'b0;
    logic [WORD_W-1:0] boundary_tick = '0;
    logic [WORD_W-1:0] meas_cycles   = '0;
    logic [WORD_W-1:0] meas_tick     = '0;
    logic [WORD_W-1:0] rate          = '0;
    logic [WORD_W-1:0] origin        = '0;
    logic [WORD_W-1:0] due           = '0;
    logic              due_in_ticks  = 1'b0;

    in_t  pending_beats[$];
    out_t expected_readings[$];
    out_t want;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          send_gap      = 0;
    int          recv_gap      = 0;
    int          hold_left     = 0;
    bit          long_hold_done = 1'b0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int unsigned bench_cycles  = 0;

    // Stimulus cursor: boundary tick used while waiting, running counters
    logic [WORD_W-1:0] wait_tick;
    logic [WORD_W-1:0] run_cycles;
    logic [WORD_W-1:0] run_tick;

    cycle_counter_timebase_calibrator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the mirror by one beat and return the reading it must produce
    function automatic out_t predict_reading(input in_t beat);
        logic [WORD_W-1:0] us_tick;
        logic [WORD_W-1:0] waited;
        logic [WORD_W-1:0] elapsed;
        logic [WORD_W-1:0] cycles;
        logic [WORD_W-1:0] ticks_needed;
        out_t              r;
        us_tick = WORD_W'(ms_tick) * US_PER_MS;
        r = '0;
        r.time_us = rate;
        case (beat.op)
            OP_CAL:
            begin
                if (cal_phase == PH_WAIT)
                begin
                    if (!tick_seen)
                    begin
                        tick_seen = 1'b1;
                        boundary_tick = beat.ref_ticks;
                    end
                    else if (beat.ref_ticks != boundary_tick)
                    begin
                        tick_seen = 1'b0;
                        meas_cycles = beat.cycle_count;
                        meas_tick = beat.ref_ticks;
                        cal_phase = PH_MEAS;
                    end
                end
                else if (cal_phase == PH_MEAS)
                begin
                    waited = beat.ref_ticks - meas_tick;
                    if (waited >= WORD_W'(cal_span))
                    begin
                        elapsed = waited * us_tick;
                        cycles = beat.cycle_count - meas_cycles;
                        if (elapsed == 0 || cycles == 0 || cycles / elapsed == 0)
                            cal_phase = PH_FAIL;
                        else
                        begin
                            rate = cycles / elapsed;
                            origin = beat.cycle_count;
                            cal_phase = PH_CAL;
                        end
                    end
                end
                r.time_us = rate;
            end
            OP_READ:
            begin
                if (cal_phase != PH_CAL || rate == 0)
                    r.time_us = beat.ref_ticks * us_tick;
                else if (beat.cycle_count < origin)
                    r.time_us = '0;
                else
                    r.time_us = (beat.cycle_count - origin) / rate;
            end
            OP_ARM:
            begin
                if (cal_phase == PH_CAL)
                begin
                    due = beat.cycle_count + WORD_W'(beat.delay_us) * rate;
                    due_in_ticks = 1'b0;
                end
                else
                begin
                    ticks_needed = (us_tick == 0) ? WORD_W'(0)
                                 : (WORD_W'(beat.delay_us) + us_tick - 1) / us_tick;
                    due = beat.ref_ticks + ticks_needed;
                    due_in_ticks = 1'b1;
                end
            end
            default:
            begin
                if (due_in_ticks)
                    r.delay_done = (beat.ref_ticks >= due);
                else
                    r.delay_done = (beat.cycle_count >= due);
            end
        endcase
        r.cal_status = cal_phase;
        return r;
    endfunction

    // Sender: offer queued beats, idle in bursts, hold a stalled beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_readings.push_back(predict_reading(in_data));
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 && $urandom_range(99, 0) < send_idle_pct)
                begin
                    send_gap <= $urandom_range(10, 0);
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_beats.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result beat, stall in bursts and once for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result %h arrived with nothing expected", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_data.time_us !== want.time_us)
                    begin
                        $display("%0t: time_us expected %0h got %0h",
                                 $time, want.time_us, out_data.time_us);
                        mismatches++;
                    end
                    if (out_data.cal_status !== want.cal_status)
                    begin
                        $display("%0t: cal_status expected %0d got %0d",
                                 $time, want.cal_status, out_data.cal_status);
                        mismatches++;
                    end
                    if (out_data.delay_done !== want.delay_done)
                    begin
                        $display("%0t: delay_done expected %0b got %0b",
                                 $time, want.delay_done, out_data.delay_done);
                        mismatches++;
                    end
                end
            end
            if (!long_hold_done && results_seen >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left <= LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(99, 0) < recv_idle_pct)
            begin
                recv_gap <= $urandom_range(10, 0);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        bench_cycles <= bench_cycles + 1;
        if (bench_cycles == LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Random value of random magnitude
    function automatic logic [WORD_W-1:0] rnd_span();
        return rnd64() >> $urandom_range(63, 0);
    endfunction

    function automatic logic [DLY_W-1:0] pick_delay();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return '1;
            2: return DLY_W'($urandom_range(50_000, 1));
            default: return $urandom >> $urandom_range(31, 0);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_ms_per_tick(input bit allow_zero);
        case ($urandom_range(5, 0))
            0: return allow_zero ? CFG_W'(0) : CFG_W'(1);
            1: return CFG_W'(1);
            2: return CFG_W'(1023);
            3: return CFG_W'(1000);
            default: return CFG_W'($urandom_range(1023, 1));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_cal_ticks();
        case ($urandom_range(4, 0))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(255);
            3: return CFG_W'(50);
            default: return CFG_W'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(3, 0))
            0: return 0;
            1: return 10;
            2: return 25;
            default: return 40;
        endcase
    endfunction

    task automatic add_beat(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] cyc,
                            input logic [WORD_W-1:0] ticks, input logic [DLY_W-1:0] dly);
        in_t b;
        b.op = op;
        b.cycle_count = cyc;
        b.ref_ticks = ticks;
        b.delay_us = dly;
        pending_beats.push_back(b);
    endtask

    // Wait until every queued beat is accepted and every reading has come back
    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
    endtask

    // Write one register while the block is idle and update the mirror
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] data;
        data = val;
        // unused upper bits of the narrow register carry noise
        if (idx == CFG_CAL_TICKS)
            data[CFG_W-1:CALT_W] = (CFG_W-CALT_W)'($urandom_range(3, 0));
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MS_PER_TICK)
            ms_tick = data[MS_W-1:0];
        else
            cal_span = data[CALT_W-1:0];
    endtask

    // Arm a delay, then poll just around its deadline
    task automatic arm_and_poll(input logic [WORD_W-1:0] cyc, input logic [WORD_W-1:0] ticks,
                                input bit calibrated);
        logic [DLY_W-1:0]  dly;
        logic [WORD_W-1:0] per;
        logic [WORD_W-1:0] target;
        logic [WORD_W-1:0] off;
        dly = pick_delay();
        add_beat(OP_ARM, cyc, ticks, dly);
        if (calibrated)
            target = cyc + WORD_W'(dly) * rate;
        else
        begin
            per = WORD_W'(ms_tick) * US_PER_MS;
            target = ticks + ((per == 0) ? WORD_W'(0) : (WORD_W'(dly) + per - 1) / per);
        end
        repeat ($urandom_range(3, 0))
        begin
            case ($urandom_range(4, 0))
                0: off = ALL_ONES;
                1: off = '0;
                2: off = WORD_W'(1);
                3: off = -(rnd_span() >> 8);
                default: off = rnd_span() >> 8;
            endcase
            if (calibrated)
                add_beat(OP_POLL, target + off, rnd64(), $urandom);
            else
                add_beat(OP_POLL, rnd64(), target + off, $urandom);
        end
    endtask

    // Mixed traffic in the current calibration phase
    task automatic gen_mixed(input int count);
        bit calibrated;
        bit waiting;
        int sel;
        calibrated = (cal_phase == PH_CAL);
        waiting = (cal_phase == PH_WAIT);
        repeat (count)
        begin
            sel = $urandom_range(99, 0);
            run_cycles = run_cycles + WORD_W'($urandom_range(5000, 1));
            if ($urandom_range(3, 0) == 0)
                run_tick = run_tick + 1;
            if (sel < 8)
                add_beat(waiting ? OP_W'($urandom_range(3, 1)) : OP_W'($urandom_range(3, 0)),
                         rnd64(), rnd64(), $urandom);
            else if (sel < 32)
            begin
                if (calibrated && $urandom_range(9, 0) == 0)
                    add_beat(OP_READ, origin - 1 - (rnd_span() >> 1), rnd64(), $urandom);
                else if (calibrated)
                    add_beat(OP_READ, origin + rnd_span(), rnd64(), $urandom);
                else
                    add_beat(OP_READ, rnd64(),
                             ($urandom_range(4, 0) == 0) ? rnd64() : run_tick, $urandom);
            end
            else if (sel < 55)
                arm_and_poll(($urandom_range(3, 0) == 0) ? rnd64() : run_cycles,
                             ($urandom_range(3, 0) == 0) ? rnd64() : run_tick, calibrated);
            else if (sel < 85)
                add_beat(OP_POLL, run_cycles, run_tick, $urandom);
            else if (waiting)
                add_beat(OP_CAL, rnd64(), wait_tick, $urandom);
            else
                add_beat(OP_CAL, rnd64(), rnd64(), $urandom);
        end
    endtask

    initial
    begin
        int                mode;
        logic [WORD_W-1:0] st;
        logic [WORD_W-1:0] sc;
        logic [WORD_W-1:0] ec;
        logic [WORD_W-1:0] waited;
        logic [WORD_W-1:0] elapsed;
        logic [WORD_W-1:0] ratio;
        logic [WORD_W-1:0] tk;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait_tick = rnd64();
        run_cycles = rnd64();
        run_tick = wait_tick;

        // Directed: poll before any arm, the boundary wait, field extremes, tick deadlines
        add_beat(OP_POLL, '0, '0, '0);
        add_beat(OP_CAL, '0, wait_tick, '1);
        add_beat(OP_READ, '0, '0, '0);
        add_beat(OP_READ, ALL_ONES, ALL_ONES, '1);
        add_beat(OP_READ, rnd64(), rnd64(), $urandom);
        add_beat(OP_ARM, ALL_ONES, WORD_W'(5), DLY_W'(1));
        add_beat(OP_POLL, ALL_ONES, WORD_W'(5), '0);
        add_beat(OP_POLL, '0, WORD_W'(6), '0);
        add_beat(OP_ARM, '0, ALL_ONES, '1);
        add_beat(OP_POLL, '0, ALL_ONES, '0);
        add_beat(OP_POLL, '0, '0, '0);
        add_beat(OP_ARM, rnd64(), WORD_W'(100), '0);
        add_beat(OP_POLL, rnd64(), WORD_W'(99), '1);
        add_beat(OP_POLL, rnd64(), WORD_W'(100), '0);
        add_beat(OP_CAL, ALL_ONES, wait_tick, '0);
        wait_drained();

        // Zero tick length: no elapsed time and a zero tick delay
        write_reg(CFG_MS_PER_TICK, CFG_W'(0));
        write_reg(CFG_CAL_TICKS, CFG_W'(255));
        tk = rnd64();
        add_beat(OP_READ, rnd64(), rnd64(), $urandom);
        add_beat(OP_ARM, rnd64(), tk, '1);
        add_beat(OP_POLL, rnd64(), tk - 1, '0);
        add_beat(OP_POLL, rnd64(), tk, '0);
        wait_drained();

        // Longest tick: rounding of the largest delay
        write_reg(CFG_MS_PER_TICK, CFG_W'(1023));
        write_reg(CFG_CAL_TICKS, CFG_W'(0));
        add_beat(OP_ARM, rnd64(), ALL_ONES - 10, '1);
        add_beat(OP_POLL, rnd64(), ALL_ONES, '0);
        add_beat(OP_READ, rnd64(), ALL_ONES, '0);
        wait_drained();

        // Uncalibrated random traffic over several tick lengths
        repeat (3)
        begin
            write_reg(CFG_MS_PER_TICK, pick_ms_per_tick(1'b1));
            write_reg(CFG_CAL_TICKS, pick_cal_ticks());
            send_idle_pct = pick_idle();
            recv_idle_pct = pick_idle();
            gen_mixed(70);
            wait_drained();
        end

        // The one calibration run: mostly a good measurement, sometimes a failing one
        case ($urandom_range(9, 0))
            0: mode = CAL_NO_CYCLES;
            1: mode = CAL_SLOW;
            2: mode = CAL_NO_TIME;
            default: mode = CAL_GOOD;
        endcase
        write_reg(CFG_MS_PER_TICK, (mode == CAL_NO_TIME) ? CFG_W'(0) : pick_ms_per_tick(1'b0));
        write_reg(CFG_CAL_TICKS, pick_cal_ticks());
        send_idle_pct = pick_idle();
        recv_idle_pct = pick_idle();
        repeat ($urandom_range(3, 1))
            add_beat(OP_CAL, rnd64(), wait_tick, $urandom);
        st = ($urandom_range(3, 0) == 0) ? ALL_ONES - WORD_W'($urandom_range(3, 0))
                                         : wait_tick + WORD_W'($urandom_range(4, 1));
        if (st == wait_tick)
            st = st + 1;
        sc = rnd64();
        add_beat(OP_CAL, sc, st, $urandom);
        // measure, with samples short of the tick count and other traffic between
        repeat ($urandom_range(8, 3))
        begin
            if (cal_span > 1 && $urandom_range(1, 0) == 1)
                add_beat(OP_CAL, rnd64(), st + WORD_W'($urandom_range(int'(cal_span) - 1, 0)),
                         $urandom);
            else if ($urandom_range(1, 0) == 1)
                add_beat(OP_READ, rnd64(), st + WORD_W'($urandom_range(300, 0)), $urandom);
            else
                arm_and_poll(rnd64(), st, 1'b0);
        end
        waited = WORD_W'(cal_span) + WORD_W'($urandom_range(2, 0));
        if (waited == 0)
            waited = 1;
        elapsed = waited * (WORD_W'(ms_tick) * US_PER_MS);
        case ($urandom_range(3, 0))
            0: ratio = WORD_W'(1);
            1: ratio = WORD_W'($urandom_range(5000, 1));
            2: ratio = WORD_W'($urandom_range(1 << 20, 1));
            default: ratio = WORD_W'($urandom_range(32'hFFFF_FFFF, 1));
        endcase
        if (mode == CAL_NO_CYCLES)
            ec = sc;
        else if (mode == CAL_SLOW)
            ec = sc + rnd64() % (elapsed - 1) + 1;
        else if (mode == CAL_NO_TIME)
            ec = rnd64();
        else
            ec = sc + elapsed * ratio + rnd64() % elapsed;
        add_beat(OP_CAL, ec, st + waited, $urandom);
        wait_drained();
        run_cycles = origin;

        // Directed after the run: origin, counter going backwards, wrapping deadlines
        add_beat(OP_READ, origin, rnd64(), $urandom);
        add_beat(OP_READ, origin - 1, rnd64(), $urandom);
        add_beat(OP_READ, ALL_ONES, ALL_ONES, '1);
        add_beat(OP_ARM, ALL_ONES, ALL_ONES, '1);
        add_beat(OP_POLL, ALL_ONES, '0, '0);
        add_beat(OP_POLL, '0, ALL_ONES, '0);
        add_beat(OP_CAL, rnd64(), rnd64(), $urandom);
        wait_drained();

        // Random traffic after calibration, register settings varied between batches
        repeat (5)
        begin
            write_reg(CFG_MS_PER_TICK, pick_ms_per_tick(1'b1));
            write_reg(CFG_CAL_TICKS, pick_cal_ticks());
            send_idle_pct = pick_idle();
            recv_idle_pct = pick_idle();
            gen_mixed(130);
            wait_drained();
        end

        // Closing batch at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_mixed(100);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_readings.size() != 0)
        begin
            $display("%0t: %0d expected readings never arrived", $time,
                     expected_readings.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
